FILE: rtl/core/irf_pkg.sv
// Shared types and constants for the integer radix formatter.
// Used by the controller, the datapath and the top level; depends on nothing.
package irf_pkg;

	// Field widths fixed by the stream format
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned RADIX_W  = 6;
	localparam int unsigned WIDTH_W  = 7;
	localparam int unsigned CHAR_W   = 7;
	localparam int unsigned DIGIT_W  = 6;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned IN_TDATA_W  = 80;
	localparam int unsigned OUT_TDATA_W = 8;

	// Digit stack and text length limits
	localparam int unsigned STACK_DEPTH = 64;
	localparam int unsigned STACK_AW    = 6;
	localparam logic [7:0]  OUT_LIMIT   = 8'd64;

	// Division step: quotient bits resolved per cycle
	localparam int unsigned STEP_BITS = 8;

	// Base range
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_SPACE  = 7'h20;
	localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2D;
	localparam logic [CHAR_W-1:0] LETTER_BASE = 7'h37; // 'A' - 10
	localparam logic [DIGIT_W-1:0] LAST_DECIMAL = 6'd9;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // take a new request
		logic div_step;  // resolve the next quotient byte
		logic store;     // push the remainder onto the digit stack
		logic prep;      // work out padding and text length
		logic send;      // load the next character into the output register
	} irf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_last;     // current division step is the final one
		logic more_digits;  // quotient non-zero and stack not full
		logic out_free;     // output register can take a character
		logic char_last;    // next character to send is the final one
	} irf_sts_t;

	// Map a digit value to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d <= LAST_DECIMAL) begin
			c = CHAR_ZERO + {1'b0, d};
		end else begin
			c = LETTER_BASE + {1'b0, d};
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/irf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependency.
module irf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/irf_datapath.sv
// Datapath of the integer radix formatter: divider, digit stack, character output.
// Depends on irf_pkg and irf_ram.
module irf_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  irf_pkg::irf_cmd_t               cmd,
	output irf_pkg::irf_sts_t               sts,
	input  logic [irf_pkg::VALUE_W-1:0]     value_bits,
	input  logic                            is_signed,
	input  logic [irf_pkg::RADIX_W-1:0]     radix,
	input  logic [irf_pkg::WIDTH_W-1:0]     min_width,
	input  logic                            pad_with_zero,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [irf_pkg::CHAR_W-1:0]      out_char,
	output logic                            is_last
);
	import irf_pkg::*;

	logic [VALUE_W-1:0]  quot_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [2:0]          step_q;
	logic [COUNT_W-1:0]  dcnt_q;
	logic                neg_q;
	logic [RADIX_W-1:0]  base_q;
	logic [WIDTH_W-1:0]  width_q;
	logic                zfill_q;
	logic [COUNT_W-1:0]  pads_q;
	logic [COUNT_W-1:0]  total_q;
	logic [COUNT_W-1:0]  k_q;
	logic [STACK_AW-1:0] ptr_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;

	logic                neg_in;
	logic [VALUE_W-1:0]  mag_in;
	logic [RADIX_W-1:0]  base_in;
	logic [DIGIT_W-1:0]  rem_nxt;
	logic [STEP_BITS-1:0] qbits;
	logic [7:0]          text_len;
	logic [7:0]          pads_raw;
	logic [7:0]          pads_cap;
	logic [7:0]          total_raw;
	logic [7:0]          total_cap;
	logic [DIGIT_W-1:0]  stack_rdata;
	logic                is_pad;
	logic                is_minus;
	logic [CHAR_W-1:0]   char_nxt;

	// Sign, magnitude and clamped base of the incoming request
	always_comb begin
		neg_in  = is_signed & value_bits[VALUE_W-1];
		mag_in  = neg_in ? VALUE_W'(~value_bits + 64'd1) : value_bits;
		if (radix < RADIX_MIN) begin
			base_in = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			base_in = RADIX_MAX;
		end else begin
			base_in = radix;
		end
	end

	// Restoring division over the top quotient byte
	always_comb begin
		logic [DIGIT_W:0] t;
		logic [DIGIT_W-1:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, quot_q[VALUE_W-1-i]};
			if (t >= {1'b0, base_q}) begin
				t = t - {1'b0, base_q};
				qbits[STEP_BITS-1-i] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_nxt = r;
	end

	// Padding and text length, capped at the output limit
	always_comb begin
		text_len  = {1'b0, dcnt_q} + {7'b0, neg_q};
		pads_raw  = ({1'b0, width_q} > text_len) ? ({1'b0, width_q} - text_len) : 8'd0;
		pads_cap  = (pads_raw > OUT_LIMIT) ? OUT_LIMIT : pads_raw;
		total_raw = pads_cap + text_len;
		total_cap = (total_raw > OUT_LIMIT) ? OUT_LIMIT : total_raw;
	end

	// Pick the character at position k
	always_comb begin
		is_pad   = (k_q < pads_q);
		is_minus = !is_pad && neg_q && (k_q == pads_q);
		if (is_pad) begin
			char_nxt = zfill_q ? CHAR_ZERO : CHAR_SPACE;
		end else if (is_minus) begin
			char_nxt = CHAR_MINUS;
		end else begin
			char_nxt = digit_char(stack_rdata);
		end
	end

	// Digit stack
	irf_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(dcnt_q[STACK_AW-1:0]),
		.wdata(rem_q),
		.raddr(ptr_q),
		.rdata(stack_rdata)
	);

	// Control counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			dcnt_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				step_q <= '0;
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 3'd1;
			end else if (cmd.store) begin
				dcnt_q <= dcnt_q + 7'd1;
			end
			if (cmd.prep) begin
				k_q <= '0;
			end else if (cmd.send) begin
				k_q <= k_q + 7'd1;
			end
			if (cmd.send) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q  <= mag_in;
			rem_q   <= '0;
			neg_q   <= neg_in;
			base_q  <= base_in;
			width_q <= min_width;
			zfill_q <= pad_with_zero;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[VALUE_W-STEP_BITS-1:0], qbits};
			rem_q  <= rem_nxt;
		end else if (cmd.store) begin
			rem_q <= '0;
		end
		if (cmd.prep) begin
			pads_q  <= pads_cap[COUNT_W-1:0];
			total_q <= total_cap[COUNT_W-1:0];
			ptr_q   <= dcnt_q[STACK_AW-1:0] - 6'd1;
		end else if (cmd.send && !is_pad && !is_minus) begin
			ptr_q <= ptr_q - 6'd1;
		end
		if (cmd.send) begin
			out_char_q <= char_nxt;
			out_last_q <= (k_q == total_q - 7'd1);
		end
	end

	// Status back to the controller
	assign sts.div_last    = &step_q;
	assign sts.more_digits = (quot_q != '0) && (dcnt_q != 7'(STACK_DEPTH - 1));
	assign sts.out_free    = !out_valid_q || out_ready;
	assign sts.char_last   = (k_q == total_q - 7'd1);

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign is_last   = out_last_q;

endmodule

FILE: rtl/core/irf_ctrl.sv
// Controller of the integer radix formatter: sequences division, stacking and output.
// Depends on irf_pkg.
module irf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  irf_pkg::irf_sts_t sts,
	output irf_pkg::irf_cmd_t cmd
);
	import irf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_PREP,
		ST_FETCH,
		ST_SEND
	} state_t;

	state_t state_q;
	logic   rdy_q;

	// Decode commands from the current state
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid && rdy_q;
		cmd.div_step = (state_q == ST_DIV);
		cmd.store    = (state_q == ST_STORE);
		cmd.prep     = (state_q == ST_PREP);
		cmd.send     = (state_q == ST_SEND) && sts.out_free;
	end

	// State and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && rdy_q) begin
						rdy_q   <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					state_q <= sts.more_digits ? ST_DIV : ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (sts.out_free) begin
						if (sts.char_last) begin
							rdy_q   <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					rdy_q   <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = rdy_q;

endmodule

FILE: rtl/core/integer_radix_formatter.sv
// Top level of the integer radix formatter: stream ports, controller and datapath.
// Depends on irf_pkg, irf_ctrl and irf_datapath (which holds the irf_ram digit stack).
//
// Usage:
//   The slave stream takes one request per number; s_tuser carries the signed flag.
//   The master stream returns the formatted text one ASCII character per beat,
//   most significant character first, with m_tlast on the final character.
//   Fill characters come first, then '-' for a negative signed value, then digits.
//   Text longer than 64 characters is cut to its first 64.
// Sequence:
//   Each digit is found by dividing the 64-bit quotient a byte per cycle through
//   the restoring divider and then pushing the remainder onto the digit stack.
//   Padding and text length are then set up, and each character is read from the
//   stack and then loaded into the output register. s_tready is high only between
//   items; the next request is taken while the last character still waits in the
//   output register.
// Reset and stall:
//   arst_n clears the controller and empties the output register. When m_tready is
//   low the current character holds in the output register and the block waits.
module integer_radix_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [63:0] value_bits, [69:64] radix, [76:70] min_width, [77] pad_with_zero
	input  logic [79:0] s_tdata,
	// [0] is_signed
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] out_char
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);
	import irf_pkg::*;

	irf_cmd_t          cmd;
	irf_sts_t          sts;
	logic [CHAR_W-1:0] out_char;

	// Sequencer
	irf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Divider, digit stack and output register
	irf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value_bits   (s_tdata[63:0]),
		.is_signed    (s_tuser),
		.radix        (s_tdata[69:64]),
		.min_width    (s_tdata[76:70]),
		.pad_with_zero(s_tdata[77]),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_char     (out_char),
		.is_last      (m_tlast)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the integer radix formatter stream block.
// Depends on irf_pkg and the integer_radix_formatter top level; a class predicts the text.

// Expected text of every accepted request, one character per entry
class radix_text_board;
	typedef struct {
		logic [6:0] ch;
		bit         last;
	} text_char_t;

	text_char_t expected_chars[$];
	int         mismatches;

	function new();
		mismatches = 0;
	endfunction

	function int pending();
		return expected_chars.size();
	endfunction

	// Format one number and queue its characters
	function void note_request(logic [63:0] value_bits, bit is_signed, logic [5:0] radix,
			logic [6:0] min_width, bit pad_with_zero);
		logic [63:0] base;
		logic [63:0] mag;
		logic [63:0] quot;
		logic [5:0]  digits[64];
		logic [6:0]  text[$];
		logic [5:0]  d;
		int          n_dig;
		int          text_len;
		int          pads;
		int          total;
		bit          neg;
		text_char_t  item;

		// Clamp the base into 2..36
		base = 64'(radix);
		if (base < 64'(irf_pkg::RADIX_MIN)) base = 64'(irf_pkg::RADIX_MIN);
		if (base > 64'(irf_pkg::RADIX_MAX)) base = 64'(irf_pkg::RADIX_MAX);

		neg = is_signed && value_bits[63];
		mag = neg ? (~value_bits + 64'd1) : value_bits;

		// Peel digits off, least significant first
		n_dig = 0;
		quot = mag;
		do begin
			digits[n_dig] = 6'(quot % base);
			n_dig++;
			quot = quot / base;
		end while (quot != 0 && n_dig < 64);

		text_len = n_dig + (neg ? 1 : 0);
		pads = (int'(min_width) > text_len) ? int'(min_width) - text_len : 0;
		if (pads > 64) pads = 64;
		total = pads + text_len;
		if (total > 64) total = 64;

		// Fill first, then sign, then digits most significant first
		repeat (pads) text.push_back(pad_with_zero ? irf_pkg::CHAR_ZERO : irf_pkg::CHAR_SPACE);
		if (neg) text.push_back(irf_pkg::CHAR_MINUS);
		for (int i = n_dig - 1; i >= 0; i--) begin
			d = digits[i];
			if (d <= irf_pkg::LAST_DECIMAL) begin
				text.push_back(irf_pkg::CHAR_ZERO + {1'b0, d});
			end else begin
				text.push_back(irf_pkg::LETTER_BASE + {1'b0, d});
			end
		end

		// Cut to the output limit and flag the final character
		for (int k = 0; k < total; k++) begin
			item.ch = text[k];
			item.last = (k == total - 1);
			expected_chars.push_back(item);
		end
	endfunction

	// Compare one delivered character with the oldest expectation
	function void check_char(logic [6:0] ch, logic last);
		text_char_t exp_c;
		if (expected_chars.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected character: char=%h last=%b", ch, last);
			return;
		end
		exp_c = expected_chars.pop_front();
		if (ch !== exp_c.ch || last !== exp_c.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("character mismatch: expected char=%h last=%b, got char=%h last=%b",
					exp_c.ch, exp_c.last, ch, last);
		end
	endfunction
endclass

module tb;
	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [63:0] value_bits, [69:64] radix, [76:70] min_width, [77] pad_with_zero
	logic [79:0] s_tdata;
	// [0] is_signed
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [6:0] out_char
	logic [7:0]  m_tdata;
	logic        m_tlast;

	radix_text_board text_board = new();
	bit              calm = 1'b0;

	integer_radix_formatter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Free-running clock, period 20
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle with a chance of 16 in a hundred, never during the calm stretch
	function automatic bit want_idle();
		return !calm && ($urandom_range(0, 99) < 16);
	endfunction

	// Offer one request, with a random gap in front, and note it once taken
	task automatic send_request(input logic [63:0] value_bits, input bit is_signed,
			input logic [5:0] radix, input logic [6:0] min_width, input bit pad_with_zero);
		if (want_idle()) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (want_idle());
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, pad_with_zero, min_width, radix, value_bits};
		s_tuser  <= is_signed;
		do @(posedge clk); while (!s_tready);
		text_board.note_request(value_bits, is_signed, radix, min_width, pad_with_zero);
	endtask

	// Random request with values biased towards interesting shapes
	task automatic send_random_request();
		logic [63:0] v;
		logic [5:0]  rdx;
		logic [6:0]  w;
		case ($urandom_range(0, 4))
			0: v = 64'($urandom_range(0, 1000));
			1: v = -64'($urandom_range(1, 1000));
			2: v = 64'd1 << $urandom_range(0, 63);
			3: v = ~(64'd1 << $urandom_range(0, 63));
			default: v = {$urandom, $urandom};
		endcase
		if ($urandom_range(0, 9) == 0) rdx = 6'($urandom_range(0, 63));
		else rdx = 6'($urandom_range(2, 36));
		case ($urandom_range(0, 19))
			0, 1, 2: w = 7'($urandom_range(0, 127));
			3, 4, 5, 6, 7: w = 7'($urandom_range(0, 64));
			default: w = 7'($urandom_range(0, 24));
		endcase
		send_request(v, 1'($urandom_range(0, 1)), rdx, w, 1'($urandom_range(0, 1)));
	endtask

	// Receive side: check each character, stall at random
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				text_board.check_char(m_tdata[6:0], m_tlast);
			m_tready <= arst_n && !want_idle();
		end
	end

	// Reset, directed requests, random requests, drain
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero, all ones, the most negative value and the largest positive one
		send_request(64'd0, 1'b0, 6'd10, 7'd0, 1'b0);
		send_request(64'd0, 1'b1, 6'd2, 7'd64, 1'b1);
		send_request('1, 1'b0, 6'd2, 7'd0, 1'b0);
		send_request('1, 1'b1, 6'd10, 7'd0, 1'b0);
		send_request(64'h8000_0000_0000_0000, 1'b1, 6'd2, 7'd0, 1'b0);
		send_request(64'h8000_0000_0000_0000, 1'b1, 6'd16, 7'd20, 1'b0);
		send_request(64'h8000_0000_0000_0000, 1'b1, 6'd10, 7'd0, 1'b1);
		send_request(64'h8000_0000_0000_0000, 1'b0, 6'd2, 7'd0, 1'b0);
		send_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd36, 7'd0, 1'b0);
		send_request('1, 1'b0, 6'd36, 7'd0, 1'b0);
		send_request('1, 1'b0, 6'd3, 7'd0, 1'b0);
		// Bases out of range fold to 2 or 36
		send_request(64'd5, 1'b0, 6'd0, 7'd0, 1'b0);
		send_request(64'd5, 1'b0, 6'd1, 7'd0, 1'b0);
		send_request(64'd35, 1'b0, 6'd37, 7'd0, 1'b0);
		send_request(64'd12345, 1'b0, 6'd63, 7'd0, 1'b0);
		// Letters and the last decimal digit
		send_request(64'd35, 1'b0, 6'd36, 7'd0, 1'b0);
		send_request(64'd10, 1'b0, 6'd11, 7'd0, 1'b0);
		send_request(64'd9, 1'b0, 6'd10, 7'd0, 1'b0);
		// Padding: wide minimum, fill in front of the sign, exact fit
		send_request(64'd42, 1'b0, 6'd10, 7'd127, 1'b0);
		send_request(-64'd7, 1'b1, 6'd8, 7'd127, 1'b1);
		send_request(-64'd123, 1'b1, 6'd10, 7'd64, 1'b0);
		send_request(-64'd123, 1'b1, 6'd10, 7'd8, 1'b1);
		send_request(64'd255, 1'b1, 6'd16, 7'd2, 1'b1);
		send_request(64'd255, 1'b1, 6'd16, 7'd5, 1'b1);

		// Random part, with a stretch where neither side idles
		for (int n = 0; n < 346; n++) begin
			calm = (n >= 120 && n < 200);
			send_random_request();
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// Wait for the text to drain, then allow for any late characters
		while (text_board.pending() != 0) @(posedge clk);
		repeat (750) @(posedge clk);

		if (text_board.mismatches == 0 && text_board.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end
endmodule
